[rtl/ring_neighbour_difference_5x5_defines.svh]
// assertion macros shared by the ring neighbour difference rtl
// no dependencies; taken in by the files that carry assertions
`ifndef RING_NEIGHBOUR_DIFFERENCE_5X5_DEFINES_SVH
`define RING_NEIGHBOUR_DIFFERENCE_5X5_DEFINES_SVH

// same-cycle implication, off during reset
`define RND_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, off during reset
`define RND_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/rnd_pkg.sv]
// types, constants and ring tables for the ring neighbour difference block
// no dependencies
package rnd_pkg;

   localparam int PIXEL_BITS      = 16;
   localparam int DIFF_BITS       = PIXEL_BITS + 1;
   localparam int RING_COUNT      = 16;
   localparam int IDX_BITS        = 4;
   localparam int WIN_SIZE        = 5;
   localparam int WIN_EDGE        = WIN_SIZE - 1;
   localparam int LINE_COUNT      = 4;
   localparam int MIN_SIZE        = 5;
   localparam int MAX_HEIGHT      = 4096;
   localparam int ROW_BITS        = 12;
   localparam int COL_BITS        = 10;
   localparam int WIDTH_CFG_BITS  = 11;
   localparam int HEIGHT_CFG_BITS = 13;
   localparam int CSR_INDEX_BITS  = 2;
   localparam int CSR_DATA_BITS   = 13;
   localparam int QUEUE_DEPTH     = 2;
   localparam int QCNT_BITS       = $clog2(QUEUE_DEPTH + 1);
   localparam int QPTR_BITS       = $clog2(QUEUE_DEPTH);

   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_HEIGHT = 2'd1;

   localparam logic [WIDTH_CFG_BITS-1:0]  WIDTH_RESET  = 11'd78;
   localparam logic [HEIGHT_CFG_BITS-1:0] HEIGHT_RESET = 13'd36;

   localparam logic [IDX_BITS-1:0] RING_LAST = IDX_BITS'(RING_COUNT - 1);

   typedef struct packed {
      logic signed [PIXEL_BITS-1:0] pixel;
      logic                         plane_start;
   } req_type;

   typedef struct packed {
      logic signed [DIFF_BITS-1:0] difference;
      logic [IDX_BITS-1:0]         ring_index;
      logic [ROW_BITS-1:0]         out_row;
      logic [COL_BITS-1:0]         out_col;
      logic                        last;
   } rsp_type;

   typedef logic [PIXEL_BITS-1:0] pix_type;

   // [row][col], col WIN_EDGE is the newest column
   typedef pix_type [WIN_SIZE-1:0][WIN_SIZE-1:0] win_type;

   // one line store word: entry k is input row r-4+k at that column
   typedef pix_type [LINE_COUNT-1:0] line_word_type;

   typedef struct packed {
      pix_type                        centre;
      pix_type [RING_COUNT-1:0]       ring;
      logic [ROW_BITS-1:0]            out_row;
      logic [COL_BITS-1:0]            out_col;
   } job_type;

   typedef struct packed {
      logic                 empty;
      logic [QCNT_BITS-1:0] count;
   } q_status_type;

   // ring walk: top row, right column, bottom row, left column
   function automatic logic [2:0] ring_row(input logic [IDX_BITS-1:0] k);
      logic [2:0] r;
      unique case (k)
         4'd0, 4'd1, 4'd2, 4'd3, 4'd4:       r = 3'd0;
         4'd5, 4'd13:                        r = 3'd1;
         4'd6, 4'd14:                        r = 3'd2;
         4'd7, 4'd15:                        r = 3'd3;
         default:                            r = 3'd4;
      endcase
      return r;
   endfunction

   function automatic logic [2:0] ring_col(input logic [IDX_BITS-1:0] k);
      logic [2:0] c;
      unique case (k)
         4'd0, 4'd8, 4'd13, 4'd14, 4'd15:    c = 3'd0;
         4'd1, 4'd9:                         c = 3'd1;
         4'd2, 4'd10:                        c = 3'd2;
         4'd3, 4'd11:                        c = 3'd3;
         default:                            c = 3'd4;
      endcase
      return c;
   endfunction

endpackage

[rtl/rnd_ram.sv]
// generic single-write, single-read ram with registered read data
// no dependencies
module rnd_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

[rtl/rnd_front.sv]
// front end: config registers, raster counters, line store and 5x5 window
// depends on rnd_pkg, rnd_ram and the assertion macro header
`include "ring_neighbour_difference_5x5_defines.svh"

module rnd_front #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  rnd_pkg::req_type                      req_data,
   input  logic                                  csr_write,
   input  logic [rnd_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [rnd_pkg::CSR_DATA_BITS-1:0]     csr_data,
   input  rnd_pkg::q_status_type                 q_status,
   output logic                                  push,
   output rnd_pkg::job_type                      push_data
);

   localparam int CW   = $clog2(MAX_WIDTH);
   localparam int CMPW = ($clog2(MAX_WIDTH + 1) > rnd_pkg::HEIGHT_CFG_BITS) ?
                         $clog2(MAX_WIDTH + 1) : rnd_pkg::HEIGHT_CFG_BITS;
   localparam int LWW  = rnd_pkg::LINE_COUNT * rnd_pkg::PIXEL_BITS;

   logic [rnd_pkg::WIDTH_CFG_BITS-1:0]  width_cfg_ff, width_cfg_in;
   logic [rnd_pkg::HEIGHT_CFG_BITS-1:0] height_cfg_ff, height_cfg_in;
   logic [CW-1:0]                       col_ff, col_in;
   logic [rnd_pkg::ROW_BITS-1:0]        row_ff, row_in;

   logic                                p1_valid_ff, p1_valid_in;
   logic                                p1_emit_ff;
   rnd_pkg::pix_type                    p1_pixel_ff;
   logic [CW-1:0]                       p1_addr_ff;
   logic [rnd_pkg::ROW_BITS-1:0]        p1_row_ff;
   logic [rnd_pkg::COL_BITS-1:0]        p1_col_ff;
   logic                                fwd_ff, fwd_in;
   rnd_pkg::line_word_type              fwd_data_ff;
   rnd_pkg::win_type                    win_ff, win_in;

   logic                                accept;
   logic [CW-1:0]                       col_cur;
   logic [rnd_pkg::ROW_BITS-1:0]        row_cur;
   logic [CMPW-1:0]                     w_raw, w_eff, h_raw, h_eff;
   logic [CMPW-1:0]                     col_inc, row_inc, col_m4;
   logic                                emit;
   logic [rnd_pkg::ROW_BITS-1:0]        row_m4;
   logic [LWW-1:0]                      ram_rdata;
   rnd_pkg::line_word_type              line_word, wr_word;
   rnd_pkg::pix_type [rnd_pkg::WIN_SIZE-1:0] column;
   logic [rnd_pkg::QCNT_BITS:0]         occupancy;

   assign accept = req_valid && !req_stall;

   // slots taken, counting an item in flight toward the queue
   assign occupancy = {1'b0, q_status.count} +
                      (rnd_pkg::QCNT_BITS + 1)'(p1_valid_ff && p1_emit_ff);
   assign req_stall = occupancy >= (rnd_pkg::QCNT_BITS + 1)'(rnd_pkg::QUEUE_DEPTH);

   // configuration
   always_comb begin
      width_cfg_in  = width_cfg_ff;
      height_cfg_in = height_cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            rnd_pkg::CSR_IMAGE_WIDTH:
               width_cfg_in = csr_data[rnd_pkg::WIDTH_CFG_BITS-1:0];
            rnd_pkg::CSR_IMAGE_HEIGHT:
               height_cfg_in = csr_data;
            default: begin
            end
         endcase
      end
   end

   // clamp sizes into the legal range
   always_comb begin
      w_raw = CMPW'(width_cfg_ff);
      h_raw = CMPW'(height_cfg_ff);
      if (w_raw < CMPW'(rnd_pkg::MIN_SIZE)) begin
         w_eff = CMPW'(rnd_pkg::MIN_SIZE);
      end else if (w_raw > CMPW'(MAX_WIDTH)) begin
         w_eff = CMPW'(MAX_WIDTH);
      end else begin
         w_eff = w_raw;
      end
      if (h_raw < CMPW'(rnd_pkg::MIN_SIZE)) begin
         h_eff = CMPW'(rnd_pkg::MIN_SIZE);
      end else if (h_raw > CMPW'(rnd_pkg::MAX_HEIGHT)) begin
         h_eff = CMPW'(rnd_pkg::MAX_HEIGHT);
      end else begin
         h_eff = h_raw;
      end
   end

   // raster position of the incoming item
   always_comb begin
      col_cur = req_data.plane_start ? '0 : col_ff;
      row_cur = req_data.plane_start ? '0 : row_ff;
      col_inc = CMPW'(col_cur) + CMPW'(1);
      row_inc = CMPW'(row_cur) + CMPW'(1);
      col_in  = col_ff;
      row_in  = row_ff;
      if (accept) begin
         if (col_inc >= w_eff) begin
            col_in = '0;
            row_in = (row_inc >= h_eff) ? '0 : row_inc[rnd_pkg::ROW_BITS-1:0];
         end else begin
            col_in = col_inc[CW-1:0];
            row_in = row_cur;
         end
      end
      emit   = (row_cur >= rnd_pkg::ROW_BITS'(rnd_pkg::WIN_EDGE)) &&
               (CMPW'(col_cur) >= CMPW'(rnd_pkg::WIN_EDGE));
      col_m4 = CMPW'(col_cur) - CMPW'(rnd_pkg::WIN_EDGE);
      row_m4 = row_cur - rnd_pkg::ROW_BITS'(rnd_pkg::WIN_EDGE);
   end

   rnd_ram #(
      .WIDTH (LWW),
      .DEPTH (MAX_WIDTH)
   ) u_line_store (
      .clock (clock),
      .we    (p1_valid_ff),
      .waddr (p1_addr_ff),
      .wdata (wr_word),
      .re    (accept),
      .raddr (col_cur),
      .rdata (ram_rdata)
   );

   // second stage: column assembly, line store write back, window shift
   always_comb begin
      line_word = fwd_ff ? fwd_data_ff : rnd_pkg::line_word_type'(ram_rdata);
      for (int k = 0; k < rnd_pkg::LINE_COUNT; k++) begin
         column[k] = line_word[k];
      end
      column[rnd_pkg::WIN_EDGE] = p1_pixel_ff;
      for (int k = 0; k < rnd_pkg::LINE_COUNT; k++) begin
         wr_word[k] = column[k + 1];
      end
      win_in = win_ff;
      if (p1_valid_ff) begin
         for (int r = 0; r < rnd_pkg::WIN_SIZE; r++) begin
            for (int c = 0; c < rnd_pkg::WIN_EDGE; c++) begin
               win_in[r][c] = win_ff[r][c + 1];
            end
            win_in[r][rnd_pkg::WIN_EDGE] = column[r];
         end
      end
      // same column read again right after its write: take the fresh word
      fwd_in      = accept && p1_valid_ff && (col_cur == p1_addr_ff);
      p1_valid_in = accept;
   end

   always_comb begin
      push              = p1_valid_ff && p1_emit_ff;
      push_data.centre  = win_in[2][2];
      for (int k = 0; k < rnd_pkg::RING_COUNT; k++) begin
         push_data.ring[k] = win_in[rnd_pkg::ring_row(rnd_pkg::IDX_BITS'(k))]
                                   [rnd_pkg::ring_col(rnd_pkg::IDX_BITS'(k))];
      end
      push_data.out_row = p1_row_ff;
      push_data.out_col = p1_col_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_cfg_ff  <= rnd_pkg::WIDTH_RESET;
         height_cfg_ff <= rnd_pkg::HEIGHT_RESET;
         col_ff        <= '0;
         row_ff        <= '0;
         p1_valid_ff   <= 1'b0;
         fwd_ff        <= 1'b0;
      end else begin
         width_cfg_ff  <= width_cfg_in;
         height_cfg_ff <= height_cfg_in;
         col_ff        <= col_in;
         row_ff        <= row_in;
         p1_valid_ff   <= p1_valid_in;
         fwd_ff        <= fwd_in;
      end
   end

   always_ff @(posedge clock) begin
      win_ff      <= win_in;
      fwd_data_ff <= wr_word;
      if (accept) begin
         p1_emit_ff  <= emit;
         p1_pixel_ff <= req_data.pixel;
         p1_addr_ff  <= col_cur;
         p1_row_ff   <= row_m4;
         p1_col_ff   <= col_m4[rnd_pkg::COL_BITS-1:0];
      end
   end

   `RND_ASSERT_NEXT(a_plane_start_quiet, clock, reset, accept && req_data.plane_start, !push, "plane start item produced results")

endmodule

[rtl/rnd_queue.sv]
// short job queue between the window front end and the result sequencer
// depends on rnd_pkg and the assertion macro header
`include "ring_neighbour_difference_5x5_defines.svh"

module rnd_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  rnd_pkg::job_type      push_data,
   input  logic                  pop,
   output rnd_pkg::job_type      head,
   output rnd_pkg::q_status_type q_status
);

   rnd_pkg::job_type                entry_ff [rnd_pkg::QUEUE_DEPTH];
   logic [rnd_pkg::QPTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [rnd_pkg::QPTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [rnd_pkg::QCNT_BITS-1:0]   count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + rnd_pkg::QPTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + rnd_pkg::QPTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff + rnd_pkg::QCNT_BITS'(push) - rnd_pkg::QCNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head           = entry_ff[rd_ptr_ff];
   assign q_status.empty = (count_ff == '0);
   assign q_status.count = count_ff;

   `RND_ASSERT_SAME(a_no_overflow, clock, reset, push, count_ff < rnd_pkg::QCNT_BITS'(rnd_pkg::QUEUE_DEPTH), "job queue overflow")
   `RND_ASSERT_SAME(a_no_underflow, clock, reset, pop, count_ff != '0, "job queue underflow")

endmodule

[rtl/rnd_back.sv]
// back end: walks the 16 ring positions of the head job, one result per cycle while the result channel is not stalled
// depends on rnd_pkg and the assertion macro header
`include "ring_neighbour_difference_5x5_defines.svh"

module rnd_back (
   input  logic                  clock,
   input  logic                  reset,
   input  rnd_pkg::job_type      head,
   input  rnd_pkg::q_status_type q_status,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rnd_pkg::rsp_type      rsp_data
);

   logic [rnd_pkg::IDX_BITS-1:0] idx_ff, idx_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   rnd_pkg::rsp_type             rsp_data_ff, rsp_data_in;
   logic                         load;
   rnd_pkg::pix_type             ring_pix;

   // output register refills when a job is waiting and it is empty or being taken
   assign load = !q_status.empty && (!rsp_valid_ff || !rsp_stall);
   assign pop  = load && (idx_ff == rnd_pkg::RING_LAST);

   always_comb begin
      ring_pix                = head.ring[idx_ff];
      rsp_data_in.difference  = $signed({head.centre[rnd_pkg::PIXEL_BITS-1], head.centre})
                              - $signed({ring_pix[rnd_pkg::PIXEL_BITS-1], ring_pix});
      rsp_data_in.ring_index  = idx_ff;
      rsp_data_in.out_row     = head.out_row;
      rsp_data_in.out_col     = head.out_col;
      rsp_data_in.last        = (idx_ff == rnd_pkg::RING_LAST);
      idx_in                  = load ? idx_ff + rnd_pkg::IDX_BITS'(1) : idx_ff;
      rsp_valid_in            = load || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `RND_ASSERT_NEXT(a_burst_unbroken, clock, reset, rsp_valid_ff && !rsp_stall && !rsp_data_ff.last, rsp_valid_ff, "gap inside a 16-result burst")

endmodule

[rtl/ring_neighbour_difference_5x5.sv]
// Ring neighbour difference over a 5x5 window of a raster-order pixel plane.
// Every pixel at row 4 or more and column 4 or more yields 16 results, centre
// minus each outer ring pixel, sent one per cycle while the result channel is
// not stalled; the back-end sequencer walks the ring. Pixels of the first four
// rows and columns give no result and are taken one per cycle while the job
// queue has room. A two-entry job queue lets the front end take the next pixel
// while a burst is still going out. Results of a pixel pass through the front
// stage register, the job queue and the back-end output register. The four line
// stores live in one ram of MAX_WIDTH words; they are not cleared, so the
// block is ready right after reset. Configuration writes are taken at once.
// depends on rnd_pkg, rnd_front, rnd_queue and rnd_back
module ring_neighbour_difference_5x5 #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  rnd_pkg::req_type                   req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output rnd_pkg::rsp_type                   rsp_data,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [rnd_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [rnd_pkg::CSR_DATA_BITS-1:0]  csr_data
);

   logic                  push;
   logic                  pop;
   rnd_pkg::job_type      push_data;
   rnd_pkg::job_type      head;
   rnd_pkg::q_status_type q_status;

   assign csr_ready = 1'b1;

   rnd_front #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .csr_write (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .q_status  (q_status),
      .push      (push),
      .push_data (push_data)
   );

   rnd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head      (head),
      .q_status  (q_status)
   );

   rnd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .q_status  (q_status),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

[tb/sv/ring_neighbour_difference_5x5_checker.sv]
// checker for the ring neighbour difference block: follows the pixel, result and
// register channels, predicts every ring difference and compares results in order
// depends on rnd_pkg
module ring_neighbour_difference_5x5_checker #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_stall,
   input  rnd_pkg::req_type                   req_data,
   input  logic                               rsp_valid,
   input  logic                               rsp_stall,
   input  rnd_pkg::rsp_type                   rsp_data,
   input  logic                               csr_valid,
   input  logic                               csr_ready,
   input  logic [rnd_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [rnd_pkg::CSR_DATA_BITS-1:0]  csr_data,
   output int                                 outstanding,
   output int                                 mismatch_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CENTRE = rnd_pkg::WIN_SIZE / 2;

   typedef logic signed [rnd_pkg::PIXEL_BITS-1:0] spix_type;

   spix_type                            line_mem [rnd_pkg::LINE_COUNT][MAX_WIDTH];
   spix_type                            win [rnd_pkg::WIN_SIZE][rnd_pkg::WIN_SIZE];
   int unsigned                         col_count;
   int unsigned                         row_count;
   logic [rnd_pkg::WIDTH_CFG_BITS-1:0]  width_reg;
   logic [rnd_pkg::HEIGHT_CFG_BITS-1:0] height_reg;
   rnd_pkg::rsp_type                    pending_differences [$];
   rnd_pkg::rsp_type                    oldest;

   function automatic int unsigned clamp_extent(input int unsigned v, input int unsigned hi);
      if (v < rnd_pkg::MIN_SIZE)
         return rnd_pkg::MIN_SIZE;
      if (v > hi)
         return hi;
      return v;
   endfunction

   function automatic void push_ring_differences(input rnd_pkg::req_type item);
      int unsigned      w_eff;
      int unsigned      h_eff;
      int unsigned      c;
      int unsigned      r;
      int unsigned      k;
      int unsigned      j;
      int unsigned      ring_r;
      int unsigned      ring_c;
      int               diff;
      spix_type         fresh [rnd_pkg::WIN_SIZE];
      rnd_pkg::rsp_type exp_rsp;
      w_eff = clamp_extent(32'(width_reg), MAX_WIDTH);
      h_eff = clamp_extent(32'(height_reg), rnd_pkg::MAX_HEIGHT);
      if (item.plane_start) begin
         col_count = 0;
         row_count = 0;
      end
      c = col_count;
      r = row_count;
      if (c >= MAX_WIDTH)
         c = 0;
      // new window column: four stored rows, oldest first, then the incoming pixel
      for (k = 0; k < rnd_pkg::LINE_COUNT; k++)
         fresh[k] = line_mem[k][c];
      fresh[rnd_pkg::WIN_EDGE] = item.pixel;
      for (k = 0; k < rnd_pkg::LINE_COUNT; k++)
         line_mem[k][c] = fresh[k+1];
      for (k = 0; k < rnd_pkg::WIN_SIZE; k++) begin
         for (j = 0; j < rnd_pkg::WIN_EDGE; j++)
            win[k][j] = win[k][j+1];
         win[k][rnd_pkg::WIN_EDGE] = fresh[k];
      end
      if (r >= rnd_pkg::WIN_EDGE && c >= rnd_pkg::WIN_EDGE) begin
         for (k = 0; k < rnd_pkg::RING_COUNT; k++) begin
            // top row, right column, bottom row, left column
            if (k < 5) begin
               ring_r = 0;
               ring_c = k;
            end else if (k < 8) begin
               ring_r = k - 4;
               ring_c = rnd_pkg::WIN_EDGE;
            end else if (k < 13) begin
               ring_r = rnd_pkg::WIN_EDGE;
               ring_c = k - 8;
            end else begin
               ring_r = k - 12;
               ring_c = 0;
            end
            diff = int'(win[CENTRE][CENTRE]) - int'(win[ring_r][ring_c]);
            exp_rsp.difference = rnd_pkg::DIFF_BITS'(diff);
            exp_rsp.ring_index = rnd_pkg::IDX_BITS'(k);
            exp_rsp.out_row    = rnd_pkg::ROW_BITS'(r - rnd_pkg::WIN_EDGE);
            exp_rsp.out_col    = rnd_pkg::COL_BITS'(c - rnd_pkg::WIN_EDGE);
            exp_rsp.last       = (k == rnd_pkg::RING_COUNT - 1);
            pending_differences.push_back(exp_rsp);
         end
      end
      c++;
      if (c >= w_eff) begin
         c = 0;
         r++;
         if (r >= h_eff)
            r = 0;
      end
      col_count = c;
      row_count = r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         foreach (line_mem[i, j])
            line_mem[i][j] = '0;
         foreach (win[i, j])
            win[i][j] = '0;
         col_count = 0;
         row_count = 0;
         width_reg = rnd_pkg::WIDTH_RESET;
         height_reg = rnd_pkg::HEIGHT_RESET;
         pending_differences.delete();
         mismatch_count = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_differences.size() == 0) begin
               mismatch_count++;
               $display("%0t unexpected result %0d/%0d/%0d/%0d/%0b", $time,
                        rsp_data.difference, rsp_data.ring_index, rsp_data.out_row,
                        rsp_data.out_col, rsp_data.last);
            end else begin
               oldest = pending_differences.pop_front();
               if (rsp_data.difference !== oldest.difference ||
                   rsp_data.ring_index !== oldest.ring_index ||
                   rsp_data.out_row !== oldest.out_row ||
                   rsp_data.out_col !== oldest.out_col ||
                   rsp_data.last !== oldest.last) begin
                  mismatch_count++;
                  $display("%0t mismatch exp %0d/%0d/%0d/%0d/%0b got %0d/%0d/%0d/%0d/%0b",
                           $time, oldest.difference, oldest.ring_index, oldest.out_row,
                           oldest.out_col, oldest.last, rsp_data.difference,
                           rsp_data.ring_index, rsp_data.out_row, rsp_data.out_col,
                           rsp_data.last);
               end
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               rnd_pkg::CSR_IMAGE_WIDTH:  width_reg = csr_data[rnd_pkg::WIDTH_CFG_BITS-1:0];
               rnd_pkg::CSR_IMAGE_HEIGHT: height_reg = csr_data;
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            push_ring_differences(req_data);
      end
      outstanding = pending_differences.size();
   end

endmodule

[tb/sv/ring_neighbour_difference_5x5_test.sv]
// top of the ring neighbour difference test: clock, single reset, size register
// writes between phases, pixel planes under changing idle patterns, and the verdict
// depends on rnd_pkg, ring_neighbour_difference_5x5 and its checker module
module ring_neighbour_difference_5x5_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_WIDTH     = 1024;
   localparam int WIDE_ITEMS    = 16;
   localparam int RANDOM_ITEMS  = 390;
   localparam int SETTLE_CYCLES = 12;
   localparam int LONG_HOLD     = 400;
   localparam int CYCLE_LIMIT   = 1000000;

   typedef logic [rnd_pkg::CSR_DATA_BITS-1:0] csr_word_type;
   typedef logic [rnd_pkg::PIXEL_BITS-1:0]    pixel_word_type;

   localparam logic [rnd_pkg::CSR_INDEX_BITS-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [rnd_pkg::CSR_INDEX_BITS-1:0] CSR_SPARE_B = 2'd3;

   localparam logic [8*rnd_pkg::PIXEL_BITS-1:0] EDGE_VALUES = {
      16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h0001, 16'h5555, 16'hAAAA, 16'h4000};

   logic                               clock;
   logic                               reset;
   logic                               req_valid;
   logic                               req_stall;
   rnd_pkg::req_type                   req_data;
   logic                               rsp_valid;
   logic                               rsp_stall;
   rnd_pkg::rsp_type                   rsp_data;
   logic                               csr_valid;
   logic                               csr_ready;
   logic [rnd_pkg::CSR_INDEX_BITS-1:0] csr_index;
   csr_word_type                       csr_data;
   int                                 outstanding;
   int                                 mismatch_count;
   int                                 req_idle_pct = 0;
   int                                 rsp_idle_pct = 0;
   int                                 holds_asked = 0;
   int                                 cycle_count;
   int                                 cur_width;

   ring_neighbour_difference_5x5 #(
      .MAX_WIDTH (MAX_WIDTH)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   ring_neighbour_difference_5x5_checker #(
      .MAX_WIDTH (MAX_WIDTH)
   ) ring_watch (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .outstanding    (outstanding),
      .mismatch_count (mismatch_count)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAIL");
      $finish;
   end

   // result side: random stalls, plus a long hold on request
   initial begin : receiver
      int holds_done;
      int hold_left;
      holds_done = 0;
      hold_left = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (holds_asked != holds_done) begin
            holds_done = holds_asked;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall = 1'b1;
         end else
            rsp_stall = ($urandom_range(99) < rsp_idle_pct);
      end
   end

   function automatic pixel_word_type pick_pixel();
      if ($urandom_range(3) == 0)
         return EDGE_VALUES[$urandom_range(7)*rnd_pkg::PIXEL_BITS +: rnd_pkg::PIXEL_BITS];
      return pixel_word_type'($urandom);
   endfunction

   // called and left at a falling edge; valid stays up for a following item
   task automatic send_pixel(input pixel_word_type px, input logic mark);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_data.pixel = px;
      req_data.plane_start = mark;
      do
         @(posedge clock);
      while (req_stall);
      @(negedge clock);
   endtask

   task automatic write_reg(input logic [rnd_pkg::CSR_INDEX_BITS-1:0] index,
                            input csr_word_type value);
      csr_valid = 1'b1;
      csr_index = index;
      csr_data = value;
      do
         @(posedge clock);
      while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // pixels without results may still be in flight once the last result is out
   task automatic wait_drained();
      req_valid = 1'b0;
      while (outstanding != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   initial begin : stimulus
      int             n;
      int             count;
      int             sel;
      int             regime;
      int             random_items;
      int             phase;
      csr_word_type   raw;
      pixel_word_type px;

      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      repeat (6) @(negedge clock);
      reset = 1'b0;

      // directed plane, six wide and five high, two windows in the last row
      write_reg(CSR_SPARE_A, csr_word_type'($urandom));
      write_reg(CSR_SPARE_B, csr_word_type'($urandom));
      write_reg(rnd_pkg::CSR_IMAGE_WIDTH, 13'h1806);   // bits above the width field drop away
      write_reg(rnd_pkg::CSR_IMAGE_HEIGHT, '0);         // acts as five rows
      for (n = 0; n < 33; n++) begin
         px = EDGE_VALUES[(n % 8)*rnd_pkg::PIXEL_BITS +: rnd_pkg::PIXEL_BITS];
         // centres at full scale against opposite full-scale ring pixels
         case (n)
            0, 15:   px = 16'h7FFF;
            5, 14:   px = 16'h8000;
            default: ;
         endcase
         // items 30 and 31 wrap into the next plane unmarked, 32 restarts it
         send_pixel(px, n == 0 || n == 32);
      end
      wait_drained();

      // all-ones sizes act as the upper bounds; a short run inside the first row
      write_reg(rnd_pkg::CSR_IMAGE_WIDTH, '1);
      write_reg(rnd_pkg::CSR_IMAGE_HEIGHT, '1);
      for (n = 0; n < WIDE_ITEMS; n++)
         send_pixel(pick_pixel(), n == 0);
      wait_drained();

      random_items = 0;
      phase = 0;
      while (random_items < RANDOM_ITEMS) begin
         regime = random_items * 3 / RANDOM_ITEMS;
         case (regime)
            0: begin
               req_idle_pct = 28;
               rsp_idle_pct = 51;
            end
            1: begin
               req_idle_pct = 51;
               rsp_idle_pct = 28;
            end
            default: begin
               req_idle_pct = 0;
               rsp_idle_pct = 0;
            end
         endcase

         sel = $urandom_range(9);
         if (sel == 0)
            raw = csr_word_type'($urandom_range(rnd_pkg::MIN_SIZE - 1, 0));
         else if (sel == 1)
            raw = {2'($urandom), 11'($urandom_range(12, rnd_pkg::MIN_SIZE))};
         else
            raw = csr_word_type'($urandom_range(12, rnd_pkg::MIN_SIZE));
         cur_width = (raw[rnd_pkg::WIDTH_CFG_BITS-1:0] < rnd_pkg::MIN_SIZE) ?
                     rnd_pkg::MIN_SIZE : int'(raw[rnd_pkg::WIDTH_CFG_BITS-1:0]);
         write_reg(rnd_pkg::CSR_IMAGE_WIDTH, raw);
         sel = $urandom_range(9);
         if (sel == 0)
            raw = csr_word_type'($urandom_range(rnd_pkg::MIN_SIZE - 1, 0));
         else if (sel == 1)
            raw = csr_word_type'($urandom_range(8191, rnd_pkg::MAX_HEIGHT));
         else
            raw = csr_word_type'($urandom_range(9, rnd_pkg::MIN_SIZE));
         write_reg(rnd_pkg::CSR_IMAGE_HEIGHT, raw);

         count = $urandom_range(60, 20);
         // long hold on a narrow plane: the job queue fills and the block stalls its input
         if (phase % 6 == 2) begin
            write_reg(rnd_pkg::CSR_IMAGE_WIDTH, csr_word_type'(rnd_pkg::MIN_SIZE));
            cur_width = rnd_pkg::MIN_SIZE;
            count = 60;
            holds_asked++;
         end

         for (n = 0; n < count; n++)
            send_pixel(pick_pixel(), n == 0 || $urandom_range(49) == 0);
         random_items += count;

         // size change in the middle of a plane; width never grows here
         if ($urandom_range(2) == 0) begin
            wait_drained();
            if ($urandom_range(1) == 0) begin
               raw = csr_word_type'($urandom_range(cur_width, rnd_pkg::MIN_SIZE));
               cur_width = int'(raw);
               write_reg(rnd_pkg::CSR_IMAGE_WIDTH, raw);
            end else
               write_reg(rnd_pkg::CSR_IMAGE_HEIGHT,
                         csr_word_type'($urandom_range(9, rnd_pkg::MIN_SIZE)));
            count = $urandom_range(40, 10);
            for (n = 0; n < count; n++)
               send_pixel(pick_pixel(), $urandom_range(49) == 0);
            random_items += count;
         end
         wait_drained();
         phase++;
      end

      wait_drained();
      if (mismatch_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
